/* design/top_k_smallest_selector_core_defines.svh */
// ----------------------------------------------------------------------------
// Top-K smallest selector assertion macros
// Shared macros for the concurrent assertions of the selector checker.
// ----------------------------------------------------------------------------
`ifndef TOP_K_SMALLEST_SELECTOR_CORE_DEFINES_SVH
`define TOP_K_SMALLEST_SELECTOR_CORE_DEFINES_SVH

// Assertion that is switched off while reset is asserted.
`define TKSEL_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that is checked at every clock edge, reset included.
`define TKSEL_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/tksel_pkg.sv */
// ----------------------------------------------------------------------------
// Top-K smallest selector package
// Sizes, codes and shared types of the selector.
// ----------------------------------------------------------------------------
package tksel_pkg;

    localparam int MAX_K   = 16;
    localparam int ID_BITS = 16;

    localparam int ID_W    = 16;
    localparam int DIST_W  = 32;
    localparam int RANK_W  = 5;
    localparam int K_W     = 5;
    localparam int CNT_W   = $clog2(MAX_K + 1);
    localparam int IDX_W   = (MAX_K > 1) ? $clog2(MAX_K) : 1;

    localparam logic [K_W-1:0] K_RESET = K_W'(5);

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [IDX_W-1:0] idx_t;

    typedef struct packed {
        logic insert;
        logic flush_start;
        logic load_out;
        idx_t idx;
        logic last;
    } cmd_t;

    typedef struct packed {
        cnt_t fill_n;
        logic out_free;
    } status_t;

    function automatic cnt_t clamp_k(input logic [K_W-1:0] k);
        cnt_t r;
        if (k == '0)
        begin
            r = CNT_W'(1);
        end
        else if (32'(k) > 32'(MAX_K))
        begin
            r = CNT_W'(MAX_K);
        end
        else
        begin
            r = CNT_W'(k);
        end
        return r;
    endfunction

endpackage

/* design/tksel_if.sv */
// ----------------------------------------------------------------------------
// Top-K smallest selector channel interfaces
// Valid/ready channels for candidate words and ranked result words.
// ----------------------------------------------------------------------------
interface tksel_cand_if;
    import tksel_pkg::*;

    logic              valid;
    logic              ready;
    logic              operation;
    logic [ID_W-1:0]   item_id;
    logic [DIST_W-1:0] distance;

    modport source (output valid, output operation, output item_id, output distance,
                    input ready);
    modport sink   (input valid, input operation, input item_id, input distance,
                    output ready);
endinterface

interface tksel_result_if;
    import tksel_pkg::*;

    logic              valid;
    logic              ready;
    logic [RANK_W-1:0] rank;
    logic [ID_W-1:0]   result_id;
    logic [DIST_W-1:0] result_distance;
    logic              last;

    modport source (output valid, output rank, output result_id, output result_distance,
                    output last, input ready);
    modport sink   (input valid, input rank, input result_id, input result_distance,
                    input last, output ready);
endinterface

/* design/top_k_smallest_selector_core.sv */
// One insert word is taken every cycle while idle and is sorted into the kept list.
// A flush word with n kept entries gives n result words: the first after the state
// and output registers, then one per cycle through the single output register unless
// out_ready stalls it. No candidate word is taken while a flush is being emitted; an
// empty flush emits no word. Reset empties the list, sets kept count 5, drops outputs.
// ----------------------------------------------------------------------------
// Top-K smallest selector core
// Keeps the K smallest distances in sorted order and emits them ranked on flush.
// ----------------------------------------------------------------------------
module top_k_smallest_selector_core (
    input  logic                      clk,
    input  logic                      rst_n,
    tksel_cand_if.sink                cand,
    tksel_result_if.source            result,
    input  logic                      cfg_we,
    input  logic [tksel_pkg::K_W-1:0] cfg_wdata
);
    import tksel_pkg::*;

    cmd_t    cmd;
    status_t status;

    tksel_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .cand_valid     (cand.valid),
        .cand_operation (cand.operation),
        .cand_ready     (cand.ready),
        .status         (status),
        .cmd            (cmd)
    );

    tksel_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .item_id      (cand.item_id),
        .distance     (cand.distance),
        .out_valid    (result.valid),
        .out_ready    (result.ready),
        .out_rank     (result.rank),
        .out_id       (result.result_id),
        .out_distance (result.result_distance),
        .out_last     (result.last)
    );

endmodule

/* design/tksel_ctrl.sv */
// ----------------------------------------------------------------------------
// Top-K smallest selector controller
// Accepts candidate words and sequences the ranked output of a flush.
// ----------------------------------------------------------------------------
module tksel_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cand_valid,
    input  logic              cand_operation,
    output logic              cand_ready,
    input  tksel_pkg::status_t status,
    output tksel_pkg::cmd_t    cmd
);
    import tksel_pkg::*;

    localparam logic [0:0] ST_IDLE  = 1'b0;
    localparam logic [0:0] ST_FLUSH = 1'b1;

    logic [0:0] state_reg;
    logic [0:0] state_next;
    cnt_t       cnt_reg;
    cnt_t       cnt_next;
    idx_t       idx_reg;
    idx_t       idx_next;
    logic       accept;
    logic       is_last;

    assign cand_ready = (state_reg == ST_IDLE);
    assign accept     = cand_valid && cand_ready;
    assign is_last    = (CNT_W'(idx_reg) + CNT_W'(1)) == cnt_reg;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        cmd.insert      = 1'b0;
        cmd.flush_start = 1'b0;
        cmd.load_out    = 1'b0;
        cmd.idx         = idx_reg;
        cmd.last        = is_last;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cand_operation == OP_INSERT)
                    begin
                        cmd.insert = 1'b1;
                    end
                    else
                    begin
                        cmd.flush_start = 1'b1;
                        if (status.fill_n != '0)
                        begin
                            state_next = ST_FLUSH;
                            cnt_next   = status.fill_n;
                            idx_next   = '0;
                        end
                    end
                end
            end
            ST_FLUSH:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    if (is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

/* design/tksel_datapath.sv */
// ----------------------------------------------------------------------------
// Top-K smallest selector datapath
// Sorted entry registers with parallel compare and shift, and output register.
// ----------------------------------------------------------------------------
module tksel_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tksel_pkg::cmd_t             cmd,
    output tksel_pkg::status_t          status,
    input  logic                        cfg_we,
    input  logic [tksel_pkg::K_W-1:0]   cfg_wdata,
    input  logic [tksel_pkg::ID_W-1:0]  item_id,
    input  logic [tksel_pkg::DIST_W-1:0] distance,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [tksel_pkg::RANK_W-1:0] out_rank,
    output logic [tksel_pkg::ID_W-1:0]  out_id,
    output logic [tksel_pkg::DIST_W-1:0] out_distance,
    output logic                        out_last
);
    import tksel_pkg::*;

    logic [DIST_W-1:0]  dist_reg [MAX_K];
    logic [ID_BITS-1:0] id_reg   [MAX_K];
    cnt_t               fill_reg;
    cnt_t               fill_next;
    logic [K_W-1:0]     k_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [RANK_W-1:0]  out_rank_reg;
    logic [ID_W-1:0]    out_id_reg;
    logic [DIST_W-1:0]  out_distance_reg;
    logic               out_last_reg;

    cnt_t               k_lim;
    cnt_t               n;
    logic [MAX_K-1:0]   lt;
    logic [ID_BITS-1:0] new_id;

    assign k_lim  = clamp_k(k_reg);
    assign n      = (fill_reg > k_lim) ? k_lim : fill_reg;
    assign new_id = ID_BITS'(item_id);

    assign status.fill_n   = n;
    assign status.out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        for (int i = 0; i < MAX_K; i++)
        begin
            lt[i] = (CNT_W'(i) < n) && (distance < dist_reg[i]);
        end
    end

    for (genvar g = 0; g < MAX_K; g++)
    begin : g_entry
        logic here;
        logic from_prev;
        logic wr_en;

        assign here  = (CNT_W'(g) < n) ? lt[g] : (CNT_W'(g) == n);
        assign wr_en = cmd.insert && (CNT_W'(g) < k_lim);

        if (g == 0)
        begin : g_head
            assign from_prev = 1'b0;
            always_ff @(posedge clk)
            begin
                if (wr_en && here)
                begin
                    dist_reg[g] <= distance;
                    id_reg[g]   <= new_id;
                end
            end
        end
        else
        begin : g_body
            assign from_prev = lt[g-1];
            always_ff @(posedge clk)
            begin
                if (wr_en && from_prev)
                begin
                    dist_reg[g] <= dist_reg[g-1];
                    id_reg[g]   <= id_reg[g-1];
                end
                else if (wr_en && here)
                begin
                    dist_reg[g] <= distance;
                    id_reg[g]   <= new_id;
                end
            end
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (cmd.insert)
        begin
            fill_next = (n < k_lim) ? n + CNT_W'(1) : n;
        end
        else if (cmd.flush_start)
        begin
            fill_next = '0;
        end
    end

    assign out_valid_next = cmd.load_out || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            k_reg         <= K_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                k_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_rank_reg     <= RANK_W'(CNT_W'(cmd.idx) + CNT_W'(1));
            out_id_reg       <= ID_W'(id_reg[cmd.idx]);
            out_distance_reg <= dist_reg[cmd.idx];
            out_last_reg     <= cmd.last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_rank     = out_rank_reg;
    assign out_id       = out_id_reg;
    assign out_distance = out_distance_reg;
    assign out_last     = out_last_reg;

endmodule

/* design/tksel_checker.sv */
// ----------------------------------------------------------------------------
// Top-K smallest selector checker
// Port-level assertions on flush sequencing and output word behavior.
// ----------------------------------------------------------------------------
`include "top_k_smallest_selector_core_defines.svh"

module tksel_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         cand_ready,
    input logic                         res_valid,
    input logic                         res_ready,
    input logic [tksel_pkg::RANK_W-1:0] res_rank,
    input logic [tksel_pkg::ID_W-1:0]   res_id,
    input logic                         res_last
);
    import tksel_pkg::*;

    `TKSEL_ASSERT(a_rank_steps, clk, rst_n, res_valid && res_ready && !res_last |=> res_valid && (res_rank == $past(res_rank) + RANK_W'(1)), "Ranks of one flush run do not follow each other")
    `TKSEL_ASSERT(a_no_take_in_run, clk, rst_n, res_valid && !res_last |-> !cand_ready, "Candidate word taken during a flush run")
    `TKSEL_ASSERT(a_stall_holds, clk, rst_n, res_valid && !res_ready |=> res_valid && $stable(res_id) && $stable(res_rank), "Stalled result word changed")
    `TKSEL_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |-> !res_valid, "Result word shown during reset")

endmodule

bind top_k_smallest_selector_core tksel_checker u_tksel_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cand_ready (cand.ready),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res_rank   (result.rank),
    .res_id     (result.result_id),
    .res_last   (result.last)
);
